/* rtl/vrm_pkg.sv */
package vrm_pkg;

   localparam int GRID_X_DEF = 16;
   localparam int GRID_Y_DEF = 16;
   localparam int GRID_Z_DEF = 16;

   localparam int FRAC_W    = 16;
   localparam int FIX_ONE   = 65536;
   localparam int MARCH_DIV = 50;
   localparam int STEP_Z    = FIX_ONE / MARCH_DIV;

   localparam int COORD_W = 32;
   localparam int MAG_W   = 32;
   localparam int NUM_W   = MAG_W + FRAC_W;
   localparam int DEN_W   = MAG_W + 6;
   localparam int P_W     = 48;
   localparam int COLOR_W = 24;

   localparam logic [COLOR_W-1:0] MISS_COLOR = 24'hFF00FF;

   localparam logic [1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [1:0] CSR_ORIGIN_Z = 2'd2;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_TRACE = 1'b1;

   typedef struct packed {
      logic clear_write;
      logic store_write;
      logic trace_load;
      logic den_load;
      logic div_start;
      logic div_sel;
      logic step_x_load;
      logic step_y_load;
      logic mem_read;
      logic advance;
      logic res_hit;
      logic res_miss;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic in_bounds;
      logic visible;
   } status_type;

endpackage

/* rtl/voxel_ray_march.sv */
// Voxel grid store with a fixed-step ray marcher. A write request (kind 0) stores one
// voxel and gives no response; a trace request (kind 1) marches from the origin
// registers toward its target in x and y, with z always increasing, and gives one
// response with the first visible voxel's color, or magenta with hit low. A trace first
// runs two 48-step serial divisions for the x and y step sizes; each march step then
// issues a registered read of the voxel memory before the voxel is checked. z advances
// 1/50 per step, so a ray takes at most about 50*GRID_Z steps. After reset a clearing
// pass that zeroes all GRID_X*GRID_Y*GRID_Z cells (4096 by default) runs before the
// first request is taken; csr writes are taken at any time.
module voxel_ray_march #(
   parameter int GRID_X = vrm_pkg::GRID_X_DEF,
   parameter int GRID_Y = vrm_pkg::GRID_Y_DEF,
   parameter int GRID_Z = vrm_pkg::GRID_Z_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [3:0]                         req_voxel_x,
   input  logic [3:0]                         req_voxel_y,
   input  logic [3:0]                         req_voxel_z,
   input  logic                               req_voxel_visible,
   input  logic [vrm_pkg::COLOR_W-1:0]        req_voxel_color,
   input  logic signed [vrm_pkg::COORD_W-1:0] req_target_x,
   input  logic signed [vrm_pkg::COORD_W-1:0] req_target_y,
   input  logic signed [vrm_pkg::COORD_W-1:0] req_target_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [vrm_pkg::COLOR_W-1:0]        rsp_color,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [1:0]                         csr_index,
   input  logic [31:0]                        csr_data
);
   import vrm_pkg::*;

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = 1'b1;

   vrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   vrm_datapath #(
      .GRID_X (GRID_X),
      .GRID_Y (GRID_Y),
      .GRID_Z (GRID_Z)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_voxel_x       (req_voxel_x),
      .req_voxel_y       (req_voxel_y),
      .req_voxel_z       (req_voxel_z),
      .req_voxel_visible (req_voxel_visible),
      .req_voxel_color   (req_voxel_color),
      .req_target_x      (req_target_x),
      .req_target_y      (req_target_y),
      .req_target_z      (req_target_z),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_hit           (rsp_hit),
      .rsp_color         (rsp_color)
   );

endmodule

/* rtl/vrm_div.sv */
module vrm_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [vrm_pkg::NUM_W-1:0]       num_mag,
   input  logic                            num_neg,
   input  logic [vrm_pkg::DEN_W-1:0]       den,
   output logic                            done,
   output logic signed [vrm_pkg::P_W-1:0]  quot
);
   import vrm_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]    quo_ff, quo_in;
   logic                neg_ff, neg_in;
   logic [DEN_W:0]      rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num_mag;
         neg_in  = num_neg;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den}) begin
            rem_in = DEN_W'(rem_sh - {1'b0, den});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(P_W'(quo_ff)) : $signed(P_W'(quo_ff));

endmodule

/* rtl/vrm_datapath.sv */
module vrm_datapath #(
   parameter int GRID_X = vrm_pkg::GRID_X_DEF,
   parameter int GRID_Y = vrm_pkg::GRID_Y_DEF,
   parameter int GRID_Z = vrm_pkg::GRID_Z_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  vrm_pkg::cmd_type                  cmd,
   output vrm_pkg::status_type               sts,
   input  logic [3:0]                        req_voxel_x,
   input  logic [3:0]                        req_voxel_y,
   input  logic [3:0]                        req_voxel_z,
   input  logic                              req_voxel_visible,
   input  logic [vrm_pkg::COLOR_W-1:0]       req_voxel_color,
   input  logic signed [vrm_pkg::COORD_W-1:0] req_target_x,
   input  logic signed [vrm_pkg::COORD_W-1:0] req_target_y,
   input  logic signed [vrm_pkg::COORD_W-1:0] req_target_z,
   input  logic                              csr_write,
   input  logic [1:0]                        csr_index,
   input  logic [31:0]                       csr_data,
   output logic                              rsp_hit,
   output logic [vrm_pkg::COLOR_W-1:0]       rsp_color
);
   import vrm_pkg::*;

   localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int XI_W   = $clog2(GRID_X);
   localparam int YI_W   = $clog2(GRID_Y);
   localparam int ZI_W   = $clog2(GRID_Z);
   localparam logic signed [P_W-1:0] LIM_X = P_W'(GRID_X) << FRAC_W;
   localparam logic signed [P_W-1:0] LIM_Y = P_W'(GRID_Y) << FRAC_W;
   localparam logic signed [P_W-1:0] LIM_Z = P_W'(GRID_Z) << FRAC_W;

   logic signed [COORD_W-1:0] org_x_ff, org_y_ff, org_z_ff;
   logic [MAG_W-1:0]          dx_mag_ff, dy_mag_ff, dz_mag_ff;
   logic                      dx_neg_ff, dy_neg_ff;
   logic [DEN_W-1:0]          den_ff;
   logic signed [P_W-1:0]     px_ff, py_ff, pz_ff;
   logic signed [P_W-1:0]     sx_ff, sy_ff;
   logic [ADDR_W-1:0]         clr_ff;
   logic [COLOR_W:0]          mem [CELLS];
   logic [COLOR_W:0]          mem_q_ff;
   logic                      hit_ff;
   logic [COLOR_W-1:0]        color_ff;

   logic signed [COORD_W:0]   dx, dy, dz;
   logic [COORD_W:0]          dx_abs, dy_abs, dz_abs;
   logic [MAG_W-1:0]          dz_div;
   logic                      wr_ok;
   logic [ADDR_W-1:0]         wr_addr, rd_addr;
   logic                      div_done;
   logic signed [P_W-1:0]     div_quot;
   logic [NUM_W-1:0]          div_num;

   assign dx = {req_target_x[COORD_W-1], req_target_x} - {org_x_ff[COORD_W-1], org_x_ff};
   assign dy = {req_target_y[COORD_W-1], req_target_y} - {org_y_ff[COORD_W-1], org_y_ff};
   assign dz = {req_target_z[COORD_W-1], req_target_z} - {org_z_ff[COORD_W-1], org_z_ff};
   assign dx_abs = dx[COORD_W] ? -dx : dx;
   assign dy_abs = dy[COORD_W] ? -dy : dy;
   assign dz_abs = dz[COORD_W] ? -dz : dz;
   assign dz_div = (dz_abs == '0) ? MAG_W'(FIX_ONE) : dz_abs[MAG_W-1:0];

   assign wr_ok = (int'(req_voxel_x) < GRID_X) && (int'(req_voxel_y) < GRID_Y) &&
                  (int'(req_voxel_z) < GRID_Z);
   assign wr_addr = ADDR_W'((int'(req_voxel_x) * GRID_Y + int'(req_voxel_y)) * GRID_Z
                            + int'(req_voxel_z));
   assign rd_addr = ADDR_W'((int'(px_ff[FRAC_W +: XI_W]) * GRID_Y
                            + int'(py_ff[FRAC_W +: YI_W])) * GRID_Z
                            + int'(pz_ff[FRAC_W +: ZI_W]));

   assign div_num = cmd.div_sel ? {dy_mag_ff, FRAC_W'(0)} : {dx_mag_ff, FRAC_W'(0)};

   vrm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .num_mag (div_num),
      .num_neg (cmd.div_sel ? dy_neg_ff : dx_neg_ff),
      .den     (den_ff),
      .done    (div_done),
      .quot    (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         org_z_ff <= '0;
         clr_ff   <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ORIGIN_X: org_x_ff <= csr_data;
               CSR_ORIGIN_Y: org_y_ff <= csr_data;
               CSR_ORIGIN_Z: org_z_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.clear_write) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.trace_load) begin
         dx_mag_ff <= dx_abs[MAG_W-1:0];
         dy_mag_ff <= dy_abs[MAG_W-1:0];
         dx_neg_ff <= dx[COORD_W];
         dy_neg_ff <= dy[COORD_W];
         dz_mag_ff <= dz_div;
         px_ff <= P_W'(org_x_ff);
         py_ff <= P_W'(org_y_ff);
         pz_ff <= P_W'(org_z_ff);
      end else if (cmd.advance) begin
         px_ff <= px_ff + sx_ff;
         py_ff <= py_ff + sy_ff;
         pz_ff <= pz_ff + P_W'(STEP_Z);
      end
      if (cmd.den_load) begin
         den_ff <= (DEN_W'(dz_mag_ff) << 5) + (DEN_W'(dz_mag_ff) << 4)
                   + (DEN_W'(dz_mag_ff) << 1);
      end
      if (cmd.step_x_load) begin
         sx_ff <= div_quot;
      end
      if (cmd.step_y_load) begin
         sy_ff <= div_quot;
      end
      if (cmd.res_hit) begin
         hit_ff   <= 1'b1;
         color_ff <= mem_q_ff[COLOR_W-1:0];
      end else if (cmd.res_miss) begin
         hit_ff   <= 1'b0;
         color_ff <= MISS_COLOR;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_write) begin
         mem[clr_ff] <= '0;
      end else if (cmd.store_write && wr_ok) begin
         mem[wr_addr] <= {req_voxel_visible, req_voxel_color};
      end
      if (cmd.mem_read) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   assign sts.clr_last  = (clr_ff == ADDR_W'(CELLS - 1));
   assign sts.div_done  = div_done;
   assign sts.in_bounds = !px_ff[P_W-1] && (px_ff < LIM_X) &&
                          !py_ff[P_W-1] && (py_ff < LIM_Y) &&
                          !pz_ff[P_W-1] && (pz_ff < LIM_Z);
   assign sts.visible   = mem_q_ff[COLOR_W];

   assign rsp_hit   = hit_ff;
   assign rsp_color = color_ff;

endmodule

/* rtl/vrm_ctrl.sv */
module vrm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output vrm_pkg::cmd_type    cmd,
   input  vrm_pkg::status_type sts
);
   import vrm_pkg::*;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_DEN   = 9'b000000100,
      S_XGO   = 9'b000001000,
      S_XWAIT = 9'b000010000,
      S_YGO   = 9'b000100000,
      S_YWAIT = 9'b001000000,
      S_MARCH = 9'b010000000,
      S_CHECK = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free, rsp_set;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      rsp_set  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_WRITE) begin
                  cmd.store_write = 1'b1;
               end else begin
                  cmd.trace_load = 1'b1;
                  state_in = S_DEN;
               end
            end
         end
         S_DEN: begin
            cmd.den_load = 1'b1;
            state_in = S_XGO;
         end
         S_XGO: begin
            cmd.div_start = 1'b1;
            state_in = S_XWAIT;
         end
         S_XWAIT: begin
            if (sts.div_done) begin
               cmd.step_x_load = 1'b1;
               state_in = S_YGO;
            end
         end
         S_YGO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            state_in = S_YWAIT;
         end
         S_YWAIT: begin
            cmd.div_sel = 1'b1;
            if (sts.div_done) begin
               cmd.step_y_load = 1'b1;
               state_in = S_MARCH;
            end
         end
         S_MARCH: begin
            if (sts.in_bounds) begin
               cmd.mem_read = 1'b1;
               state_in = S_CHECK;
            end else if (rsp_free) begin
               cmd.res_miss = 1'b1;
               rsp_set  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CHECK: begin
            if (sts.visible) begin
               if (rsp_free) begin
                  cmd.res_hit = 1'b1;
                  rsp_set  = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in = S_MARCH;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = rsp_set ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
